// File: rtl/core/sfd_pkg.sv
`default_nettype none

package sfd_pkg;

  localparam int DEPTH_DEF       = 131072;
  localparam int SAMPLE_BITS_DEF = 24;

  localparam int CFG_IW    = 3;
  localparam int DELAY_W   = 17;
  localparam int GAIN_W    = 16;
  localparam int CFG_DW    = DELAY_W;
  localparam int GAIN_FRAC = 15;

  typedef enum logic [CFG_IW-1:0] {
    REG_ENABLE    = 3'd0,
    REG_DELAY     = 3'd1,
    REG_FB_GAIN   = 3'd2,
    REG_MIX_GAIN  = 3'd3,
    REG_PING_PONG = 3'd4
  } cfg_reg_t;

  localparam logic               ENABLE_RST    = 1'b1;
  localparam logic [DELAY_W-1:0] DELAY_RST     = 17'd24000;
  localparam logic [GAIN_W-1:0]  FB_GAIN_RST   = 16'd16384;
  localparam logic [GAIN_W-1:0]  MIX_GAIN_RST  = 16'd16384;
  localparam logic               PING_PONG_RST = 1'b0;

endpackage

`default_nettype wire

// File: rtl/core/sfd_if.sv
`default_nettype none

interface sfd_in_if #(
  parameter int SAMPLE_BITS = sfd_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_in;
  logic signed [SAMPLE_BITS-1:0] right_in;
  logic                          block_end;

  modport source (output valid, left_in, right_in, block_end, input ready);
  modport sink   (input valid, left_in, right_in, block_end, output ready);
endinterface

interface sfd_out_if #(
  parameter int SAMPLE_BITS = sfd_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;
  logic                          block_end_out;

  modport source (output valid, left_out, right_out, block_end_out, input ready);
  modport sink   (input valid, left_out, right_out, block_end_out, output ready);
endinterface

`default_nettype wire

// File: rtl/core/stereo_feedback_delay.sv
// Stereo feedback delay with optional ping-pong cross feedback. One stereo pair
// is taken per clock cycle when the result side keeps up; a pair passes through
// the working register and then the result register on its way out. The rate is
// set by the two delay memories (one per channel), each doing one write and one
// registered read per cycle, and by the feedback path, where each pair's wet
// sample is scaled, registered and used by the very next pair. A fill count
// stands in for clearing the memories after reset, so there is no start-up pass
// and entries never written read as zero. Write configuration only while the
// block is idle.
`default_nettype none

module stereo_feedback_delay #(
  parameter int DEPTH       = sfd_pkg::DEPTH_DEF,
  parameter int SAMPLE_BITS = sfd_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  sfd_in_if.sink                           in_ch,
  sfd_out_if.source                        out_ch,
  input  wire logic                        cfg_we,
  input  wire logic [sfd_pkg::CFG_IW-1:0]  cfg_idx,
  input  wire logic [sfd_pkg::CFG_DW-1:0]  cfg_wdata
);

  localparam int SB = SAMPLE_BITS;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = AW + 1;
  localparam int DW = sfd_pkg::DELAY_W;
  localparam int GW = sfd_pkg::GAIN_W;
  localparam int CW = ((DW > AW) ? DW : AW) + 1;
  localparam int PW = SB + GW + 1;

  localparam logic [FW-1:0] DEPTH_F   = FW'(DEPTH);
  localparam logic [CW-1:0] DELAY_LIM = CW'(DEPTH - 1);
  localparam logic [AW-1:0] WP_LAST   = AW'(DEPTH - 1);

  function automatic logic signed [SB-1:0] sat1(input logic signed [SB:0] x);
    logic signed [SB-1:0] r;
    if (x[SB] != x[SB-1]) begin
      r = {x[SB], {(SB-1){~x[SB]}}};
    end else begin
      r = x[SB-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [SB-1:0] scale(input logic signed [SB-1:0] s,
                                                 input logic [GW-1:0] g);
    logic signed [PW-1:0] p;
    logic signed [SB+1:0] sh;
    logic [2:0]           top;
    logic signed [SB-1:0] r;
    p   = PW'(s) * PW'($signed({1'b0, g}));
    sh  = p[PW-1:sfd_pkg::GAIN_FRAC];
    top = sh[SB+1:SB-1];
    if ((&top) || !(|top)) begin
      r = sh[SB-1:0];
    end else begin
      r = {sh[SB+1], {(SB-1){~sh[SB+1]}}};
    end
    return r;
  endfunction

  // configuration
  logic          enable_r;
  logic [DW-1:0] delay_r;
  logic [GW-1:0] fb_gain_r;
  logic [GW-1:0] mix_gain_r;
  logic          ping_pong_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= sfd_pkg::ENABLE_RST;
      delay_r     <= sfd_pkg::DELAY_RST;
      fb_gain_r   <= sfd_pkg::FB_GAIN_RST;
      mix_gain_r  <= sfd_pkg::MIX_GAIN_RST;
      ping_pong_r <= sfd_pkg::PING_PONG_RST;
    end else if (cfg_we) begin
      unique case (sfd_pkg::cfg_reg_t'(cfg_idx))
        sfd_pkg::REG_ENABLE:    enable_r    <= cfg_wdata[0];
        sfd_pkg::REG_DELAY:     delay_r     <= cfg_wdata[DW-1:0];
        sfd_pkg::REG_FB_GAIN:   fb_gain_r   <= cfg_wdata[GW-1:0];
        sfd_pkg::REG_MIX_GAIN:  mix_gain_r  <= cfg_wdata[GW-1:0];
        sfd_pkg::REG_PING_PONG: ping_pong_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // handshake
  logic s0_v_r, out_v_r;
  logic s0_go, in_ready, in_fire;

  assign s0_go    = s0_v_r && (!out_v_r || out_ch.ready);
  assign in_ready = !s0_v_r || s0_go;
  assign in_fire  = in_ch.valid && in_ready;

  // read address for the incoming pair
  logic [AW-1:0] wp_r, wp_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [CW-1:0] d_ext, d_cl;
  logic [AW-1:0] d_a, rp;
  logic [FW-1:0] rp_wrap;

  always_comb begin
    d_ext   = CW'(delay_r);
    d_cl    = (d_ext > DELAY_LIM) ? DELAY_LIM : d_ext;
    d_a     = d_cl[AW-1:0];
    rp_wrap = {1'b0, wp_r} + DEPTH_F - {1'b0, d_a};
    rp      = (wp_r >= d_a) ? (wp_r - d_a) : rp_wrap[AW-1:0];
    wp_nxt  = (wp_r == WP_LAST) ? '0 : wp_r + 1'b1;
    fill_nxt = (fill_r != DEPTH_F) ? fill_r + 1'b1 : fill_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      fill_r <= '0;
    end else if (in_fire && enable_r) begin
      wp_r   <= wp_nxt;
      fill_r <= fill_nxt;
    end
  end

  // working register
  logic                 s0_en_r, s0_be_r, s0_d0_r, s0_ok_r;
  logic signed [SB-1:0] s0_dl_r, s0_dr_r;
  logic [AW-1:0]        s0_wp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (in_ready) begin
      s0_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s0_en_r <= enable_r;
      s0_dl_r <= in_ch.left_in;
      s0_dr_r <= in_ch.right_in;
      s0_be_r <= in_ch.block_end;
      s0_wp_r <= wp_r;
      s0_d0_r <= (d_a == '0);
      s0_ok_r <= ({1'b0, d_a} <= fill_r);
    end
  end

  // delay memories
  logic signed [SB-1:0] left_mem  [DEPTH];
  logic signed [SB-1:0] right_mem [DEPTH];
  logic signed [SB-1:0] rd_l_r, rd_r_r, byp_l_r, byp_r_r;
  logic                 byp_hit_r;
  logic                 wr_en;
  logic signed [SB-1:0] wv_l, wv_r;

  assign wr_en = s0_go && s0_en_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      left_mem[s0_wp_r]  <= wv_l;
      right_mem[s0_wp_r] <= wv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_l_r <= left_mem[rp];
      rd_r_r <= right_mem[rp];
    end
  end

  // entry written by the pair ahead in the same cycle as this read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_hit_r <= 1'b0;
    end else if (in_fire) begin
      byp_hit_r <= wr_en && (s0_wp_r == rp);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      byp_l_r <= wv_l;
      byp_r_r <= wv_r;
    end
  end

  // datapath
  logic signed [SB-1:0] fb_l_r, fb_r_r, fb_l_nxt, fb_r_nxt;
  logic signed [SB-1:0] wet_l, wet_r, sfb_l, sfb_r, smix_l, smix_r;
  logic signed [SB-1:0] res_l, res_r;

  always_comb begin
    wv_l = sat1({s0_dl_r[SB-1], s0_dl_r} + {fb_l_r[SB-1], fb_l_r});
    wv_r = sat1({s0_dr_r[SB-1], s0_dr_r} + {fb_r_r[SB-1], fb_r_r});
    priority if (s0_d0_r) begin
      wet_l = wv_l;
      wet_r = wv_r;
    end else if (byp_hit_r) begin
      wet_l = byp_l_r;
      wet_r = byp_r_r;
    end else if (s0_ok_r) begin
      wet_l = rd_l_r;
      wet_r = rd_r_r;
    end else begin
      wet_l = '0;
      wet_r = '0;
    end
    sfb_l    = scale(wet_l, fb_gain_r);
    sfb_r    = scale(wet_r, fb_gain_r);
    smix_l   = scale(wet_l, mix_gain_r);
    smix_r   = scale(wet_r, mix_gain_r);
    fb_l_nxt = ping_pong_r ? sfb_r : sfb_l;
    fb_r_nxt = ping_pong_r ? sfb_l : sfb_r;
    if (s0_en_r) begin
      res_l = sat1({s0_dl_r[SB-1], s0_dl_r} + {smix_l[SB-1], smix_l});
      res_r = sat1({s0_dr_r[SB-1], s0_dr_r} + {smix_r[SB-1], smix_r});
    end else begin
      res_l = s0_dl_r;
      res_r = s0_dr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fb_l_r <= '0;
      fb_r_r <= '0;
    end else if (wr_en) begin
      fb_l_r <= fb_l_nxt;
      fb_r_r <= fb_r_nxt;
    end
  end

  // result register
  logic signed [SB-1:0] out_l_r, out_r_r;
  logic                 out_be_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s0_go) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_go) begin
      out_l_r  <= res_l;
      out_r_r  <= res_r;
      out_be_r <= s0_be_r;
    end
  end

  assign in_ch.ready          = in_ready;
  assign out_ch.valid         = out_v_r;
  assign out_ch.left_out      = out_l_r;
  assign out_ch.right_out     = out_r_r;
  assign out_ch.block_end_out = out_be_r;

endmodule

`default_nettype wire

// File: rtl/core/sfd_checker.sv
`default_nettype none

module sfd_checker #(
  parameter int SAMPLE_BITS = sfd_pkg::SAMPLE_BITS_DEF
) (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_valid,
  input wire logic                   in_ready,
  input wire logic                   in_block_end,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire logic [SAMPLE_BITS-1:0] out_left,
  input wire logic [SAMPLE_BITS-1:0] out_right,
  input wire logic                   out_block_end
);

  logic in_xfer;
  assign in_xfer = in_valid && in_ready;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_left) && $stable(out_right)
                                && $stable(out_block_end))
    else $error("stalled result changed");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer ##1 (!out_valid || out_ready) |=> out_valid && (out_block_end == $past(in_block_end, 2)))
    else $error("accepted pair did not reach the result register");

endmodule

bind stereo_feedback_delay sfd_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_sfd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .in_block_end  (in_ch.block_end),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_left      (out_ch.left_out),
  .out_right     (out_ch.right_out),
  .out_block_end (out_ch.block_end_out)
);

`default_nettype wire

// File: sim/stereo_feedback_delay_tb.sv
`timescale 1ns / 1ps

module stereo_feedback_delay_tb;

  localparam int SW    = sfd_pkg::SAMPLE_BITS_DEF;
  localparam int DEPTH = sfd_pkg::DEPTH_DEF;
  localparam int IW    = sfd_pkg::CFG_IW;
  localparam int CDW   = sfd_pkg::CFG_DW;
  localparam int DW    = sfd_pkg::DELAY_W;
  localparam int GW    = sfd_pkg::GAIN_W;

  localparam logic [IW-1:0] REG_UNUSED_5 = 3'd5;
  localparam logic [IW-1:0] REG_UNUSED_6 = 3'd6;
  localparam logic [IW-1:0] REG_UNUSED_7 = 3'd7;

  typedef logic signed [SW-1:0] sample_t;

  localparam sample_t S_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam sample_t S_MIN = {1'b1, {(SW-1){1'b0}}};

  typedef struct {
    sample_t left;
    sample_t right;
    logic    be;
  } stereo_pair_t;

  logic clk;
  logic rst_n = 1'b0;
  logic           cfg_we;
  logic [IW-1:0]  cfg_idx;
  logic [CDW-1:0] cfg_wdata;

  sfd_in_if  in_ch ();
  sfd_out_if out_ch ();

  stereo_feedback_delay dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  stereo_pair_t dry_pairs[$];
  stereo_pair_t mixed_pairs[$];

  // echo model state
  bit signed [SW-1:0] left_store [DEPTH];
  bit signed [SW-1:0] right_store [DEPTH];
  int unsigned        wr_ptr;
  sample_t            left_fb;
  sample_t            right_fb;
  logic               cur_enable;
  logic [DW-1:0]      cur_delay;
  logic [GW-1:0]      cur_fb_gain;
  logic [GW-1:0]      cur_mix_gain;
  logic               cur_ping_pong;

  int  in_idle_max  = 0;
  int  out_idle_max = 0;
  int  in_wait      = -1;
  int  out_wait     = 0;
  int  out_hold     = 0;
  logic in_taken    = 1'b0;
  logic out_taken   = 1'b0;
  int  failures     = 0;
  int  pairs_checked = 0;
  int  passed_dry    = 0;
  int  reg_writes    = 0;
  int  settings_used = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic sample_t clip(input longint v);
    if (v > longint'(S_MAX)) return S_MAX;
    if (v < longint'(S_MIN)) return S_MIN;
    return sample_t'(v);
  endfunction

  // floor of s * g / 2^15, saturated
  function automatic sample_t apply_gain(input sample_t s, input logic [GW-1:0] g);
    longint p;
    p = longint'(s) * longint'({48'd0, g});
    return clip(p >>> sfd_pkg::GAIN_FRAC);
  endfunction

  task automatic delay_line_step(input stereo_pair_t dry, output stereo_pair_t res);
    int unsigned d;
    int unsigned rp;
    sample_t     wl;
    sample_t     wr;
    res = dry;
    if (cur_enable) begin
      d = cur_delay;
      if (d > DEPTH - 1) d = DEPTH - 1;
      left_store[wr_ptr]  = clip(longint'(dry.left) + longint'(left_fb));
      right_store[wr_ptr] = clip(longint'(dry.right) + longint'(right_fb));
      rp = (wr_ptr >= d) ? wr_ptr - d : wr_ptr + DEPTH - d;
      wl = left_store[rp];
      wr = right_store[rp];
      if (cur_ping_pong) begin
        left_fb  = apply_gain(wr, cur_fb_gain);
        right_fb = apply_gain(wl, cur_fb_gain);
      end else begin
        left_fb  = apply_gain(wl, cur_fb_gain);
        right_fb = apply_gain(wr, cur_fb_gain);
      end
      res.left  = clip(longint'(dry.left) + longint'(apply_gain(wl, cur_mix_gain)));
      res.right = clip(longint'(dry.right) + longint'(apply_gain(wr, cur_mix_gain)));
      wr_ptr = (wr_ptr == DEPTH - 1) ? 0 : wr_ptr + 1;
    end else begin
      passed_dry++;
    end
  endtask

  // sample transfers, register writes and result checks
  always @(posedge clk) begin
    stereo_pair_t got;
    stereo_pair_t want;
    stereo_pair_t dry;
    in_taken  = in_ch.valid && in_ch.ready;
    out_taken = out_ch.valid && out_ch.ready;
    if (!rst_n) begin
      wr_ptr        = 0;
      left_fb       = '0;
      right_fb      = '0;
      cur_enable    = sfd_pkg::ENABLE_RST;
      cur_delay     = sfd_pkg::DELAY_RST;
      cur_fb_gain   = sfd_pkg::FB_GAIN_RST;
      cur_mix_gain  = sfd_pkg::MIX_GAIN_RST;
      cur_ping_pong = sfd_pkg::PING_PONG_RST;
    end else begin
      if (out_taken) begin
        got.left  = out_ch.left_out;
        got.right = out_ch.right_out;
        got.be    = out_ch.block_end_out;
        if (mixed_pairs.size() == 0) begin
          $error("unexpected output transfer: left %0d right %0d", got.left, got.right);
          failures++;
        end else begin
          want = mixed_pairs.pop_front();
          pairs_checked++;
          if (got.left !== want.left) begin
            $error("left_out expected %0d got %0d", want.left, got.left);
            failures++;
          end
          if (got.right !== want.right) begin
            $error("right_out expected %0d got %0d", want.right, got.right);
            failures++;
          end
          if (got.be !== want.be) begin
            $error("block_end_out expected %0b got %0b", want.be, got.be);
            failures++;
          end
        end
      end
      if (in_taken) begin
        dry.left  = in_ch.left_in;
        dry.right = in_ch.right_in;
        dry.be    = in_ch.block_end;
        delay_line_step(dry, want);
        mixed_pairs.push_back(want);
      end
      if (cfg_we) begin
        unique case (cfg_idx)
          sfd_pkg::REG_ENABLE:    cur_enable    = cfg_wdata[0];
          sfd_pkg::REG_DELAY:     cur_delay     = cfg_wdata[DW-1:0];
          sfd_pkg::REG_FB_GAIN:   cur_fb_gain   = cfg_wdata[GW-1:0];
          sfd_pkg::REG_MIX_GAIN:  cur_mix_gain  = cfg_wdata[GW-1:0];
          sfd_pkg::REG_PING_PONG: cur_ping_pong = cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  // sender
  always @(negedge clk) begin
    stereo_pair_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_wait = -1;
    end else if (!in_ch.valid || in_taken) begin
      if (dry_pairs.size() == 0) begin
        in_ch.valid <= 1'b0;
      end else begin
        if (in_wait < 0) in_wait = $urandom_range(0, in_idle_max);
        if (in_wait > 0) begin
          in_ch.valid <= 1'b0;
          in_wait--;
        end else begin
          nxt = dry_pairs.pop_front();
          in_ch.left_in   <= nxt.left;
          in_ch.right_in  <= nxt.right;
          in_ch.block_end <= nxt.be;
          in_ch.valid     <= 1'b1;
          in_wait = -1;
        end
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_wait = 0;
    end else if (out_hold > 0) begin
      out_ch.ready <= 1'b0;
      out_hold--;
    end else begin
      if (out_taken) out_wait = $urandom_range(0, out_idle_max);
      if (out_wait > 0) begin
        out_ch.ready <= 1'b0;
        out_wait--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic cfg_write(input logic [IW-1:0] idx, input logic [CDW-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    reg_writes++;
  endtask

  task automatic cfg_release();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_settings(input logic en, input logic [DW-1:0] dly,
                                input logic [GW-1:0] fb, input logic [GW-1:0] mix,
                                input logic pp, input bit spare);
    logic [31:0] junk;
    junk = $urandom();
    cfg_write(sfd_pkg::REG_ENABLE, {junk[15:0], en});
    cfg_write(sfd_pkg::REG_DELAY, dly);
    cfg_write(sfd_pkg::REG_FB_GAIN, {junk[16], fb});
    cfg_write(sfd_pkg::REG_MIX_GAIN, {junk[17], mix});
    cfg_write(sfd_pkg::REG_PING_PONG, {junk[31:16], pp});
    if (spare) begin
      cfg_write(REG_UNUSED_5, CDW'($urandom()));
      cfg_write(REG_UNUSED_6, CDW'($urandom()));
      cfg_write(REG_UNUSED_7, CDW'($urandom()));
    end
    cfg_release();
    settings_used++;
  endtask

  task automatic queue_pair(input sample_t l, input sample_t r, input logic be);
    stereo_pair_t p;
    p.left  = l;
    p.right = r;
    p.be    = be;
    dry_pairs.push_back(p);
  endtask

  task automatic wait_idle();
    int n;
    n = 0;
    while ((dry_pairs.size() != 0 || in_ch.valid || mixed_pairs.size() != 0) && n < 20000) begin
      @(posedge clk);
      n++;
    end
    if (n >= 20000) begin
      $error("output transfers still owed: %0d", mixed_pairs.size());
      failures++;
    end
    repeat (4) @(posedge clk);
  endtask

  function automatic sample_t pick_sample();
    unique case ($urandom_range(0, 9))
      0: return S_MAX;
      1: return S_MIN;
      2, 3: return '0;
      4: return sample_t'(int'($urandom_range(0, 512)) - 256);
      default: return sample_t'($urandom());
    endcase
  endfunction

  function automatic logic [GW-1:0] pick_gain();
    unique case ($urandom_range(0, 7))
      0: return '0;
      1: return 16'd32768;
      2: return '1;
      3: return GW'($urandom_range(0, 65535));
      default: return GW'($urandom_range(0, 32768));
    endcase
  endfunction

  function automatic logic [DW-1:0] pick_delay();
    unique case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return DW'($urandom_range(0, 131071));
      3: return sfd_pkg::DELAY_RST;
      default: return DW'($urandom_range(1, 60));
    endcase
  endfunction

  function automatic int pick_idle();
    unique case ($urandom_range(0, 2))
      0: return 0;
      1: return 3;
      default: return 10;
    endcase
  endfunction

  initial begin
    int ph;
    int k;
    int n_items;
    in_ch.valid     = 1'b0;
    in_ch.left_in   = '0;
    in_ch.right_in  = '0;
    in_ch.block_end = 1'b0;
    out_ch.ready    = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = sfd_pkg::REG_ENABLE;
    cfg_wdata       = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings, long delay reads entries never written
    queue_pair(S_MAX, S_MIN, 1'b1);
    queue_pair(S_MIN, S_MAX, 1'b0);
    queue_pair('0, '1, 1'b1);
    wait_idle();

    // zero delay, unity gains, saturating feedback
    apply_settings(1'b1, '0, 16'd32768, 16'd32768, 1'b0, 1'b1);
    queue_pair(S_MAX, S_MIN, 1'b0);
    queue_pair(S_MAX, S_MIN, 1'b1);
    queue_pair(sample_t'(1), '1, 1'b0);
    queue_pair('1, sample_t'(1), 1'b0);
    wait_idle();

    // ping-pong, gains above unity, negative products floor
    apply_settings(1'b1, DW'(1), '1, '1, 1'b1, 1'b0);
    queue_pair(S_MAX, '0, 1'b0);
    queue_pair('0, '0, 1'b0);
    queue_pair('0, '0, 1'b1);
    queue_pair(sample_t'(-3), sample_t'(5), 1'b0);
    queue_pair('0, '0, 1'b0);
    wait_idle();

    // zero gains
    apply_settings(1'b1, DW'(2), '0, '0, 1'b0, 1'b0);
    queue_pair(sample_t'(1000), sample_t'(-1000), 1'b1);
    queue_pair(S_MIN, S_MAX, 1'b0);
    wait_idle();

    // bypass keeps state
    apply_settings(1'b0, DW'(1), 16'd20000, 16'd30000, 1'b1, 1'b0);
    queue_pair(S_MAX, S_MIN, 1'b1);
    queue_pair(sample_t'(123), sample_t'(-456), 1'b0);
    queue_pair('1, '0, 1'b1);
    wait_idle();

    // longest delay
    apply_settings(1'b1, '1, 16'd12345, 16'd20000, 1'b0, 1'b0);
    queue_pair(sample_t'(-7), sample_t'(7), 1'b0);
    queue_pair(S_MAX, S_MAX, 1'b1);
    queue_pair(S_MIN, S_MIN, 1'b0);
    wait_idle();

    for (ph = 0; ph < 12; ph++) begin
      apply_settings(($urandom_range(0, 7) != 0), pick_delay(), pick_gain(), pick_gain(),
                     1'($urandom_range(0, 1)), ($urandom_range(0, 3) == 0));
      in_idle_max  = pick_idle();
      out_idle_max = pick_idle();
      if (ph == 3) begin
        // long receiver stall while the sender keeps offering
        in_idle_max  = 0;
        out_idle_max = 0;
        @(posedge clk);
        out_hold = 300;
      end
      n_items = $urandom_range(140, 180);
      for (k = 0; k < n_items; k++)
        queue_pair(pick_sample(), pick_sample(), 1'($urandom_range(0, 1)));
      wait_idle();
    end

    in_idle_max  = 0;
    out_idle_max = 0;
    wait_idle();
    repeat (10) @(posedge clk);
    $display("checked %0d stereo pairs (%0d in bypass) across %0d settings, %0d register writes",
             pairs_checked, passed_dry, settings_used, reg_writes);
    $display("included a long output stall with the input held off by back-pressure");
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
